@@ design/ppt_pkg.sv @@
`default_nettype none

package ppt_pkg;

  localparam logic [15:0] IDLE_LEVEL = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_DONE     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_NONE       = 3'd3,
    ST_FINISHED   = 3'd4,
    ST_UNDERFLOW  = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] handle;
    logic [31:0] arg;
    logic [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic clr;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/ppt_cell.sv @@
`default_nettype none

module ppt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ppt_pkg::cell_ctl_t ctl,
  input  wire ppt_pkg::entry_t   d,
  input  wire ppt_pkg::entry_t   wr_data,
  output ppt_pkg::entry_t        q
);

  logic        vld_r;
  logic [31:0] handle_r;
  logic [31:0] arg_r;
  logic [15:0] prio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clr) begin
      vld_r <= 1'b0;
    end else if (ctl.wr) begin
      vld_r <= wr_data.vld;
    end else if (ctl.shift) begin
      vld_r <= d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      handle_r <= wr_data.handle;
      arg_r    <= wr_data.arg;
      prio_r   <= wr_data.prio;
    end else if (ctl.shift) begin
      handle_r <= d.handle;
      arg_r    <= d.arg;
      prio_r   <= d.prio;
    end
  end

  assign q.vld    = vld_r;
  assign q.handle = handle_r;
  assign q.arg    = arg_r;
  assign q.prio   = prio_r;

endmodule

`default_nettype wire

@@ design/preemptive_priority_task_table.sv @@
// preemptive priority task table
// command channel: drive in_kind and the task fields with start high; the beat
// is taken at an edge where start is high and busy is low. kinds: add a task,
// dispatch the best task, or mark the running task finished.
// result channel: out_valid is high for exactly one cycle with the status,
// the dispatched task (zero otherwise) and the running level after the beat.
// the receiver cannot stall; every accepted beat gives exactly one result.
// add and dispatch scan the table: the slot entries circulate once around a
// ring of cells, one slot a cycle past a single compare stage at the head of
// the ring, then the finish state applies the write, removal and level change.
// finish and unused kinds skip the scan and go straight to the finish state;
// finish uses the registered read of the level stack.
// a new beat may be accepted in the cycle the previous result is shown.
// reset: all slots empty, running level -1 (idle), level stack empty.
`default_nettype none

module preemptive_priority_task_table #(
  parameter int TABLE_SLOTS = 64,
  parameter int NEST_LIMIT  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_task_handle,
  input  wire logic [31:0] in_task_argument,
  input  wire logic signed [15:0] in_task_priority,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [31:0]      out_handle,
  output logic [31:0]      out_argument,
  output logic signed [15:0] out_priority,
  output logic signed [15:0] out_level_now
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int NC_W  = $clog2(NEST_LIMIT + 1);
  localparam int SA_W  = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;

  ppt_pkg::fsm_t state_r, state_nxt;
  logic               accept;
  logic [1:0]         kind_r;
  logic [31:0]        hdl_r;
  logic [31:0]        arg_r;
  logic [15:0]        prio_r;
  logic [IDX_W-1:0]   cnt_r;

  logic               best_found_r;
  logic signed [15:0] best_prio_r;
  logic [31:0]        best_hdl_r;
  logic [31:0]        best_arg_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;

  logic signed [15:0] level_r, level_nxt;
  logic [NC_W-1:0]    nest_r, nest_nxt;
  logic [NC_W-1:0]    nest_dec;
  logic [15:0]        stack_mem [NEST_LIMIT];
  logic [15:0]        stack_rd_r;

  ppt_pkg::entry_t    cell_q  [TABLE_SLOTS];
  ppt_pkg::cell_ctl_t cell_ctl [TABLE_SLOTS];
  ppt_pkg::entry_t    wr_data;
  ppt_pkg::entry_t    head;

  ppt_pkg::status_t   fin_status;
  logic               do_wr, do_clr, do_push;
  logic [31:0]        fin_hdl, fin_arg;
  logic [15:0]        fin_prio;
  logic               scanning, finishing;

  logic               out_valid_r;
  ppt_pkg::status_t   out_status_r;
  logic [31:0]        out_hdl_r, out_arg_r;
  logic [15:0]        out_prio_r;

  assign head   = cell_q[0];
  assign busy   = (state_r != ppt_pkg::S_IDLE);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppt_pkg::S_IDLE: begin
        if (start) begin
          if (in_kind inside {ppt_pkg::KIND_ADD, ppt_pkg::KIND_DISPATCH}) begin
            state_nxt = ppt_pkg::S_SCAN;
          end else begin
            state_nxt = ppt_pkg::S_FINISH;
          end
        end
      end
      ppt_pkg::S_SCAN: begin
        if (cnt_r == IDX_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ppt_pkg::S_FINISH;
        end
      end
      ppt_pkg::S_FINISH: state_nxt = ppt_pkg::S_IDLE;
      default:           state_nxt = ppt_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    scanning  = 1'b0;
    finishing = 1'b0;
    case (state_r)
      ppt_pkg::S_SCAN:   scanning  = 1'b1;
      ppt_pkg::S_FINISH: finishing = 1'b1;
      default: begin
        scanning  = 1'b0;
        finishing = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // beat capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= 2'd0;
      cnt_r        <= '0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (accept) begin
      kind_r       <= in_kind;
      cnt_r        <= '0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (scanning) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (head.vld && (!best_found_r || $signed(head.prio) > best_prio_r)) begin
        best_found_r <= 1'b1;
      end
      if (!head.vld && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdl_r  <= in_task_handle;
      arg_r  <= in_task_argument;
      prio_r <= in_task_priority;
    end
    if (scanning) begin
      if (head.vld && (!best_found_r || $signed(head.prio) > best_prio_r)) begin
        best_prio_r <= $signed(head.prio);
        best_hdl_r  <= head.handle;
        best_arg_r  <= head.arg;
        best_idx_r  <= cnt_r;
      end
      if (!head.vld && !free_found_r) begin
        free_idx_r <= cnt_r;
      end
    end
  end

  // ring of slot cells, head is cell 0
  assign wr_data.vld    = 1'b1;
  assign wr_data.handle = hdl_r;
  assign wr_data.arg    = arg_r;
  assign wr_data.prio   = prio_r;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    assign cell_ctl[i].shift = scanning;
    assign cell_ctl[i].wr    = do_wr  && (free_idx_r == IDX_W'(i));
    assign cell_ctl[i].clr   = do_clr && (best_idx_r == IDX_W'(i));

    ppt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl[i]),
      .d       (cell_q[(i + 1) % TABLE_SLOTS]),
      .wr_data (wr_data),
      .q       (cell_q[i])
    );
  end

  // final step of a beat
  assign nest_dec = nest_r - NC_W'(1);

  always_comb begin
    fin_status = ppt_pkg::ST_NONE;
    do_wr      = 1'b0;
    do_clr     = 1'b0;
    do_push    = 1'b0;
    fin_hdl    = '0;
    fin_arg    = '0;
    fin_prio   = '0;
    level_nxt  = level_r;
    nest_nxt   = nest_r;
    if (finishing) begin
      case (kind_r)
        ppt_pkg::KIND_ADD: begin
          if (free_found_r) begin
            fin_status = ppt_pkg::ST_ADDED;
            do_wr      = 1'b1;
          end else begin
            fin_status = ppt_pkg::ST_FULL;
          end
        end
        ppt_pkg::KIND_DISPATCH: begin
          if (!best_found_r || best_prio_r <= level_r) begin
            fin_status = ppt_pkg::ST_NONE;
          end else if (nest_r >= NC_W'(NEST_LIMIT)) begin
            fin_status = ppt_pkg::ST_OVERFLOW;
          end else begin
            fin_status = ppt_pkg::ST_DISPATCHED;
            do_clr     = 1'b1;
            do_push    = 1'b1;
            fin_hdl    = best_hdl_r;
            fin_arg    = best_arg_r;
            fin_prio   = best_prio_r;
            level_nxt  = best_prio_r;
            nest_nxt   = nest_r + NC_W'(1);
          end
        end
        ppt_pkg::KIND_DONE: begin
          if (nest_r == '0) begin
            fin_status = ppt_pkg::ST_UNDERFLOW;
          end else begin
            fin_status = ppt_pkg::ST_FINISHED;
            level_nxt  = $signed(stack_rd_r);
            nest_nxt   = nest_dec;
          end
        end
        default: fin_status = ppt_pkg::ST_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= $signed(ppt_pkg::IDLE_LEVEL);
      nest_r  <= '0;
    end else begin
      level_r <= level_nxt;
      nest_r  <= nest_nxt;
    end
  end

  // saved level stack
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[nest_r[SA_W-1:0]] <= level_r;
    end
    if (!busy) begin
      stack_rd_r <= stack_mem[nest_dec[SA_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= finishing;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      out_status_r <= fin_status;
      out_hdl_r    <= fin_hdl;
      out_arg_r    <= fin_arg;
      out_prio_r   <= fin_prio;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_handle    = out_hdl_r;
  assign out_argument  = out_arg_r;
  assign out_priority  = $signed(out_prio_r);
  assign out_level_now = level_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a beat is in flight");

  a_nest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nest_r <= NC_W'(NEST_LIMIT))
    else $error("level stack depth beyond limit");

  a_dispatch_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ppt_pkg::ST_DISPATCHED) |-> out_level_now == out_priority)
    else $error("dispatched task did not become the running level");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

@@ verif/tb_preemptive_priority_task_table.sv @@
`default_nettype none

module tb_preemptive_priority_task_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 64;
  localparam int NEST_LIMIT  = 8;
  localparam int RANDOM_CMDS = 500;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [15:0] PRI_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PRI_MIN = 16'sh8000;
  localparam logic signed [15:0] PRI_IDLE = ppt_pkg::IDLE_LEVEL;

  typedef struct {
    ppt_pkg::status_t   st;
    logic [31:0]        hdl;
    logic [31:0]        arg;
    logic signed [15:0] pri;
    logic signed [15:0] lvl;
  } outcome_t;

  typedef struct {
    logic [1:0]         kind;
    logic [31:0]        hdl;
    logic [31:0]        arg;
    logic signed [15:0] pri;
    bit                 typed;
    outcome_t           want;
  } cmd_t;

  localparam outcome_t NO_OUTCOME = '{ppt_pkg::ST_NONE, 0, 0, 0, 0};

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_kind;
  logic [31:0] in_task_handle;
  logic [31:0] in_task_argument;
  logic signed [15:0] in_task_priority;
  logic out_valid;
  logic [2:0] out_status;
  logic [31:0] out_handle;
  logic [31:0] out_argument;
  logic signed [15:0] out_priority;
  logic signed [15:0] out_level_now;

  preemptive_priority_task_table #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .NEST_LIMIT (NEST_LIMIT)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_task_handle  (in_task_handle),
    .in_task_argument(in_task_argument),
    .in_task_priority(in_task_priority),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_handle      (out_handle),
    .out_argument    (out_argument),
    .out_priority    (out_priority),
    .out_level_now   (out_level_now)
  );

  // task table mirror
  bit                 slot_used [TABLE_SLOTS];
  logic [31:0]        slot_hdl  [TABLE_SLOTS];
  logic [31:0]        slot_arg  [TABLE_SLOTS];
  logic signed [15:0] slot_pri  [TABLE_SLOTS];
  logic signed [15:0] run_lvl;
  logic signed [15:0] saved_lvl [NEST_LIMIT];
  int                 nest_depth;

  cmd_t     queued_cmds[$];
  outcome_t pending_outcomes[$];
  cmd_t     dir_rows[22];
  cmd_t     cur_cmd;
  outcome_t cur_out;
  outcome_t got;
  int       errors;
  int       sent;
  int       tally[8];
  bit       steady;

  function automatic outcome_t table_step(input logic [1:0] k, input logic [31:0] h,
                                          input logic [31:0] a, input logic signed [15:0] p);
    outcome_t r;
    int best;
    r = NO_OUTCOME;
    best = -1;
    case (k)
      ppt_pkg::KIND_ADD: begin
        r.st = ppt_pkg::ST_FULL;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_hdl[i] = h;
            slot_arg[i] = a;
            slot_pri[i] = p;
            r.st = ppt_pkg::ST_ADDED;
            break;
          end
        end
      end
      ppt_pkg::KIND_DISPATCH: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_used[i] && (best < 0 || slot_pri[i] > slot_pri[best])) best = i;
        end
        if (best < 0 || slot_pri[best] <= run_lvl) begin
          r.st = ppt_pkg::ST_NONE;
        end else if (nest_depth >= NEST_LIMIT) begin
          r.st = ppt_pkg::ST_OVERFLOW;
        end else begin
          slot_used[best] = 1'b0;
          saved_lvl[nest_depth] = run_lvl;
          nest_depth++;
          run_lvl = slot_pri[best];
          r.st = ppt_pkg::ST_DISPATCHED;
          r.hdl = slot_hdl[best];
          r.arg = slot_arg[best];
          r.pri = slot_pri[best];
        end
      end
      ppt_pkg::KIND_DONE: begin
        if (nest_depth == 0) begin
          r.st = ppt_pkg::ST_UNDERFLOW;
        end else begin
          nest_depth--;
          run_lvl = saved_lvl[nest_depth];
          r.st = ppt_pkg::ST_FINISHED;
        end
      end
      default: r.st = ppt_pkg::ST_NONE;
    endcase
    r.lvl = run_lvl;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_prio();
    int unsigned c;
    c = $urandom_range(0, 15);
    case (c)
      0: return PRI_MIN;
      1: return PRI_IDLE;
      2: return PRI_MAX;
      3: return 16'sd0;
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic issue(input logic [1:0] k, input logic [31:0] h, input logic [31:0] a,
                       input logic signed [15:0] p, input bit typed, input outcome_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    queued_cmds.push_back('{k, h, a, p, typed, w});
    start            <= 1'b1;
    in_kind          <= k;
    in_task_handle   <= h;
    in_task_argument <= a;
    in_task_priority <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k != KIND_UNUSED) sent++;
  endtask

  task automatic put(input logic [1:0] k, input logic signed [15:0] p);
    issue(k, $urandom, $urandom, p, 1'b0, NO_OUTCOME);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // accept and result beats
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      cur_cmd = queued_cmds.pop_front();
      cur_out = table_step(cur_cmd.kind, cur_cmd.hdl, cur_cmd.arg, cur_cmd.pri);
      if (cur_cmd.typed) cur_out = cur_cmd.want;
      pending_outcomes.push_back(cur_out);
    end
    if (rst_n && out_valid === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected, status %0d", out_status);
        errors++;
      end else begin
        got = pending_outcomes.pop_front();
        tally[got.st]++;
        if (out_status !== got.st) begin
          $error("status mismatch: expected %0d, got %0d", got.st, out_status);
          errors++;
        end
        if (out_handle !== got.hdl) begin
          $error("handle mismatch: expected %08h, got %08h", got.hdl, out_handle);
          errors++;
        end
        if (out_argument !== got.arg) begin
          $error("argument mismatch: expected %08h, got %08h", got.arg, out_argument);
          errors++;
        end
        if (out_priority !== got.pri) begin
          $error("priority mismatch: expected %0d, got %0d", got.pri, out_priority);
          errors++;
        end
        if (out_level_now !== got.lvl) begin
          $error("level_now mismatch: expected %0d, got %0d", got.lvl, out_level_now);
          errors++;
        end
      end
    end
  end

  initial begin
    int sel;
    int n;
    int base;
    int step;
    int pv;
    int wait_cycles;

    errors = 0;
    sent = 0;
    steady = 1'b0;
    run_lvl = PRI_IDLE;
    nest_depth = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    foreach (tally[i]) tally[i] = 0;

    dir_rows = '{
      '{ppt_pkg::KIND_DONE, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_UNDERFLOW, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_NONE, 0, 0, 0, PRI_IDLE}},
      '{KIND_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, PRI_MAX, 1'b1,
        '{ppt_pkg::ST_NONE, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_ADD, 32'hFFFFFFFF, 32'h0, PRI_IDLE, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_NONE, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_ADD, 32'h0, 32'hFFFFFFFF, PRI_MIN, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_ADD, 32'hA5A5A5A5, 32'h5A5A5A5A, PRI_MAX, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_ADD, 32'h12345678, 32'h9ABCDEF0, 0, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_ADD, 32'h0BADF00D, 32'hCAFE0001, 0, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_DISPATCHED, 32'hA5A5A5A5, 32'h5A5A5A5A, PRI_MAX, PRI_MAX}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_NONE, 0, 0, 0, PRI_MAX}},
      '{ppt_pkg::KIND_ADD, 32'h1, 32'h2, PRI_MAX, 1'b1,
        '{ppt_pkg::ST_ADDED, 0, 0, 0, PRI_MAX}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_NONE, 0, 0, 0, PRI_MAX}},
      '{ppt_pkg::KIND_DONE, 0, 0, 0, 1'b1,
        '{ppt_pkg::ST_FINISHED, 0, 0, 0, PRI_IDLE}},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DONE,     0, 0, 0, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DONE,     0, 0, 0, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DONE,     0, 0, 0, 1'b0, NO_OUTCOME},
      '{KIND_UNUSED, 32'h0, 32'h0, PRI_MIN, 1'b0, NO_OUTCOME},
      '{ppt_pkg::KIND_DISPATCH, 0, 0, 0, 1'b0, NO_OUTCOME}
    };

    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_kind          <= ppt_pkg::KIND_ADD;
    in_task_handle   <= '0;
    in_task_argument <= '0;
    in_task_priority <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].kind, dir_rows[i].hdl, dir_rows[i].arg, dir_rows[i].pri,
            dir_rows[i].typed, dir_rows[i].want);
    end
    settle();

    // deep nesting into overflow, unwind into underflow, then fill the table
    base = $urandom_range(100, 2000);
    step = $urandom_range(1, 500);
    for (int k = 0; k < NEST_LIMIT + 2; k++) begin
      pv = base + k * step;
      put(ppt_pkg::KIND_ADD, pv[15:0]);
      put(ppt_pkg::KIND_DISPATCH, 16'sd0);
    end
    repeat (NEST_LIMIT + 2) put(ppt_pkg::KIND_DONE, 16'sd0);
    repeat (TABLE_SLOTS + 4) put(ppt_pkg::KIND_ADD, rand_prio());
    repeat (40) begin
      put(ppt_pkg::KIND_DISPATCH, 16'sd0);
      put(ppt_pkg::KIND_DONE, 16'sd0);
    end
    settle();

    while (sent < RANDOM_CMDS) begin
      steady = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        n = $urandom_range(1, NEST_LIMIT + 2);
        base = $urandom_range(0, 20000);
        step = $urandom_range(1, 1500);
        for (int k = 0; k < n; k++) begin
          pv = base + k * step;
          if (pv > 32767) pv = 32767;
          put(ppt_pkg::KIND_ADD, pv[15:0]);
          put(ppt_pkg::KIND_DISPATCH, 16'sd0);
        end
        repeat ($urandom_range(0, n + 2)) put(ppt_pkg::KIND_DONE, 16'sd0);
      end else if (sel < 55) begin
        repeat ($urandom_range(1, 12)) put(ppt_pkg::KIND_ADD, rand_prio());
      end else if (sel < 60) begin
        repeat (TABLE_SLOTS + 6) put(ppt_pkg::KIND_ADD, rand_prio());
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 16)) begin
          put(ppt_pkg::KIND_DISPATCH, 16'sd0);
          put(ppt_pkg::KIND_DONE, 16'sd0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) put(2'($urandom_range(0, 3)), 16'($urandom));
      end
      if (sel % 17 == 0) settle();
    end
    steady = 1'b0;
    start <= 1'b0;
    @(posedge clk);

    wait_cycles = 0;
    while (pending_outcomes.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      errors++;
    end
    repeat (TABLE_SLOTS + 8) @(posedge clk);

    $display("%0d commands; added %0d, full %0d, dispatched %0d, none eligible %0d",
             sent, tally[ppt_pkg::ST_ADDED], tally[ppt_pkg::ST_FULL],
             tally[ppt_pkg::ST_DISPATCHED], tally[ppt_pkg::ST_NONE]);
    $display("finished %0d, finish underflow %0d, nest overflow %0d, mismatches %0d",
             tally[ppt_pkg::ST_FINISHED], tally[ppt_pkg::ST_UNDERFLOW],
             tally[ppt_pkg::ST_OVERFLOW], errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
